/* sv/evhr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evhr_pkg
// Shared types and constants for the event homography remap pipeline.
// ----------------------------------------------------------------------------
package evhr_pkg;

    // Register map of the configuration channel
    typedef enum logic [2:0] {
        REG_XNUM_XY   = 3'd0,
        REG_XC_YX     = 3'd1,
        REG_YY_YC     = 3'd2,
        REG_DEN_XY    = 3'd3,
        REG_DEN_CONST = 3'd4,
        REG_OFFSET    = 3'd5,
        REG_CANVAS    = 3'd6
    } t_reg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int EV_COORD_W = 10;
    localparam int STAMP_W    = 31;
    localparam int OUT_W      = 16;

    // Datapath widths: coefficient x coordinate, sum of three, offset product
    localparam int PROD_W = 43;
    localparam int SUM_W  = 45;
    localparam int OFFM_W = 62;
    localparam int NUM_W  = 63;
    localparam int CMP_W  = 64;
    localparam int SCL_W  = 61;
    localparam int Q_W    = 16;

    // Reset contents: identity matrix, zero offsets, 304 x 240 canvas
    localparam logic [63:0] RST_XNUM_XY   = 64'd4503599627370496;
    localparam logic [63:0] RST_XC_YX     = 64'd0;
    localparam logic [63:0] RST_YY_YC     = 64'd4503599627370496;
    localparam logic [63:0] RST_DEN_XY    = 64'd0;
    localparam logic [31:0] RST_DEN_CONST = 32'd1048576;
    localparam logic [31:0] RST_OFFSET    = 32'd0;
    localparam logic [31:0] RST_CANVAS    = 32'd19923184;

    localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;

    // Pass-through part of an event
    typedef struct packed {
        logic               pol;
        logic               chan;
        logic [STAMP_W-1:0] stamp;
    } t_meta;

    // Decisions made before the divider
    typedef struct packed {
        logic dz;
        logic negx;
        logic negy;
        logic satpx;
        logic satnx;
        logic satpy;
        logic satny;
        logic in_canvas;
        logic fwd;
    } t_flags;

endpackage

/* sv/event_homography_remap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_homography_remap
// Projective remap of address events with exact rational flags and a
// pipelined restoring divider for the truncated coordinates.
// ----------------------------------------------------------------------------
// One event enters per clock whenever start is high; busy is always low. Each
// event gives exactly one result strobe on o_done after it passes through six
// arithmetic stages (products, sums, offset multiply, offset add, sign
// normalize, compare) followed by sixteen one-bit divider stages and an output
// register. The receiver cannot stall, so results leave in input order at the
// input rate. Configuration writes are always ready and must only be issued
// while no event is in flight.
module event_homography_remap #(
    parameter int COORD_BITS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [evhr_pkg::EV_COORD_W-1:0]      i_event_x,
    input  logic [evhr_pkg::EV_COORD_W-1:0]      i_event_y,
    input  logic                                 i_event_polarity,
    input  logic                                 i_event_channel,
    input  logic [evhr_pkg::STAMP_W-1:0]         i_event_stamp,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [evhr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [evhr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_done,
    output logic signed [evhr_pkg::OUT_W-1:0]    o_mapped_x,
    output logic signed [evhr_pkg::OUT_W-1:0]    o_mapped_y,
    output logic                                 o_inside_canvas,
    output logic                                 o_forward_event,
    output logic                                 o_out_polarity,
    output logic                                 o_out_channel,
    output logic [evhr_pkg::STAMP_W-1:0]         o_out_stamp
);
    import evhr_pkg::*;

    localparam logic [EV_COORD_W-1:0] CMASK = EV_COORD_W'((1 << COORD_BITS) - 1);
    localparam int NDIV = Q_W;

    // Configuration registers
    logic [63:0] r_xnum_xy, r_xc_yx, r_yy_yc, r_den_xy;
    logic [31:0] r_den_const, r_offset, r_canvas;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    // Decode a configuration transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xnum_xy   <= RST_XNUM_XY;
            r_xc_yx     <= RST_XC_YX;
            r_yy_yc     <= RST_YY_YC;
            r_den_xy    <= RST_DEN_XY;
            r_den_const <= RST_DEN_CONST;
            r_offset    <= RST_OFFSET;
            r_canvas    <= RST_CANVAS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_XNUM_XY:   r_xnum_xy   <= i_cfg_data;
                REG_XC_YX:     r_xc_yx     <= i_cfg_data;
                REG_YY_YC:     r_yy_yc     <= i_cfg_data;
                REG_DEN_XY:    r_den_xy    <= i_cfg_data;
                REG_DEN_CONST: r_den_const <= i_cfg_data[31:0];
                REG_OFFSET:    r_offset    <= i_cfg_data[31:0];
                REG_CANVAS:    r_canvas    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Coefficient views
    logic signed [31:0] c_xx, c_xy, c_xc, c_yx, c_yy, c_yc, c_dx, c_dy, c_dc;
    logic signed [16:0] xoff1, yoff1;
    assign c_xx  = signed'(r_xnum_xy[63:32]);
    assign c_xy  = signed'(r_xnum_xy[31:0]);
    assign c_xc  = signed'(r_xc_yx[63:32]);
    assign c_yx  = signed'(r_xc_yx[31:0]);
    assign c_yy  = signed'(r_yy_yc[63:32]);
    assign c_yc  = signed'(r_yy_yc[31:0]);
    assign c_dx  = signed'(r_den_xy[63:32]);
    assign c_dy  = signed'(r_den_xy[31:0]);
    assign c_dc  = signed'(r_den_const);
    assign xoff1 = 17'(signed'(r_offset[31:16])) + 17'sd1;
    assign yoff1 = 17'(signed'(r_offset[15:0])) + 17'sd1;

    // Stage 1: coefficient products
    logic                     r1_v;
    t_meta                    r1_meta;
    logic signed [PROD_W-1:0] r1_xx, r1_xy, r1_yx, r1_yy, r1_dx, r1_dy;
    logic signed [EV_COORD_W:0] xs, ys;
    assign xs = signed'({1'b0, i_event_x & CMASK});
    assign ys = signed'({1'b0, i_event_y & CMASK});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= start && !busy;
        r1_meta <= '{pol: i_event_polarity, chan: i_event_channel, stamp: i_event_stamp};
        r1_xx   <= PROD_W'(c_xx) * PROD_W'(xs);
        r1_xy   <= PROD_W'(c_xy) * PROD_W'(ys);
        r1_yx   <= PROD_W'(c_yx) * PROD_W'(xs);
        r1_yy   <= PROD_W'(c_yy) * PROD_W'(ys);
        r1_dx   <= PROD_W'(c_dx) * PROD_W'(xs);
        r1_dy   <= PROD_W'(c_dy) * PROD_W'(ys);
    end

    // Stage 2: numerators and denominator
    logic                    r2_v;
    t_meta                   r2_meta;
    logic signed [SUM_W-1:0] r2_nx, r2_ny, r2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_meta <= r1_meta;
        r2_nx   <= SUM_W'(r1_xx) + SUM_W'(r1_xy) + SUM_W'(c_xc);
        r2_ny   <= SUM_W'(r1_yx) + SUM_W'(r1_yy) + SUM_W'(c_yc);
        r2_d    <= SUM_W'(r1_dx) + SUM_W'(r1_dy) + SUM_W'(c_dc);
    end

    // Stage 3: offset times denominator, denominator magnitude
    logic                     r3_v, r3_neg, r3_dz;
    t_meta                    r3_meta;
    logic signed [SUM_W-1:0]  r3_nx, r3_ny;
    logic signed [OFFM_W-1:0] r3_mx, r3_my;
    logic [SUM_W-1:0]         r3_ad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_meta <= r2_meta;
        r3_nx   <= r2_nx;
        r3_ny   <= r2_ny;
        r3_mx   <= OFFM_W'(xoff1) * OFFM_W'(r2_d);
        r3_my   <= OFFM_W'(yoff1) * OFFM_W'(r2_d);
        r3_ad   <= r2_d[SUM_W-1] ? SUM_W'(-r2_d) : SUM_W'(r2_d);
        r3_neg  <= r2_d[SUM_W-1];
        r3_dz   <= (r2_d == '0);
    end

    // Stage 4: shifted numerators and canvas bounds
    logic                    r4_v, r4_neg, r4_dz;
    t_meta                   r4_meta;
    logic signed [NUM_W-1:0] r4_px, r4_py;
    logic [SCL_W-1:0]        r4_wd, r4_hd;
    logic [SUM_W-1:0]        r4_ad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        r4_meta <= r3_meta;
        r4_px   <= NUM_W'(r3_nx) + NUM_W'(r3_mx);
        r4_py   <= NUM_W'(r3_ny) + NUM_W'(r3_my);
        r4_wd   <= SCL_W'(r_canvas[31:16]) * SCL_W'(r3_ad);
        r4_hd   <= SCL_W'(r_canvas[15:0]) * SCL_W'(r3_ad);
        r4_ad   <= r3_ad;
        r4_neg  <= r3_neg;
        r4_dz   <= r3_dz;
    end

    // Stage 5: normalize to a positive divisor, build thresholds
    logic                    r5_v, r5_dz;
    t_meta                   r5_meta;
    logic signed [NUM_W-1:0] r5_px, r5_py;
    logic [SCL_W-1:0]        r5_wd, r5_hd;
    logic [SUM_W-1:0]        r5_ad;
    logic [CMP_W-1:0]        r5_fd, r5_k1, r5_k2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else          r5_v <= r4_v;
        r5_meta <= r4_meta;
        r5_px   <= r4_neg ? -r4_px : r4_px;
        r5_py   <= r4_neg ? -r4_py : r4_py;
        r5_wd   <= r4_wd;
        r5_hd   <= r4_hd;
        r5_ad   <= r4_ad;
        r5_dz   <= r4_dz;
        r5_fd   <= (CMP_W'(r4_ad) << 8) - CMP_W'(r4_ad);
        r5_k1   <= CMP_W'(r4_ad) << 15;
        r5_k2   <= (CMP_W'(r4_ad) << 15) + CMP_W'(r4_ad);
    end

    // Divider pipeline arrays; entry 0 is loaded by the compare stage
    logic             r_dv   [0:NDIV];
    t_meta            r_dmeta[0:NDIV];
    t_flags           r_dflg [0:NDIV];
    logic [Q_W-1:0]   r_qx   [0:NDIV];
    logic [Q_W-1:0]   r_qy   [0:NDIV];
    logic [CMP_W-1:0] r_rx   [0:NDIV-1];
    logic [CMP_W-1:0] r_ry   [0:NDIV-1];
    logic [SUM_W-1:0] r_dad  [0:NDIV-1];

    // Stage 6: exact flags, saturation tests, magnitudes
    logic signed [CMP_W-1:0] pxs, pys;
    t_flags                  n_flg;
    assign pxs = CMP_W'(r5_px);
    assign pys = CMP_W'(r5_py);

    always_comb begin
        n_flg.dz        = r5_dz;
        n_flg.negx      = pxs[CMP_W-1];
        n_flg.negy      = pys[CMP_W-1];
        n_flg.satpx     = pxs >= signed'(r5_k1);
        n_flg.satnx     = -pxs >= signed'(r5_k2);
        n_flg.satpy     = pys >= signed'(r5_k1);
        n_flg.satny     = -pys >= signed'(r5_k2);
        n_flg.in_canvas = !r5_dz && !pxs[CMP_W-1] && (pxs < signed'(CMP_W'(r5_wd)))
                          && !pys[CMP_W-1] && (pys < signed'(CMP_W'(r5_hd)));
        n_flg.fwd       = !r5_dz && (pys <= signed'(r5_fd));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else          r_dv[0] <= r5_v;
        r_dmeta[0] <= r5_meta;
        r_dflg[0]  <= n_flg;
        r_qx[0]    <= '0;
        r_qy[0]    <= '0;
        r_rx[0]    <= pxs[CMP_W-1] ? CMP_W'(-pxs) : CMP_W'(pxs);
        r_ry[0]    <= pys[CMP_W-1] ? CMP_W'(-pys) : CMP_W'(pys);
        r_dad[0]   <= r5_ad;
    end

    // Restoring divider: one quotient bit per stage, most significant first
    for (genvar j = 1; j <= NDIV; j++) begin : g_div
        localparam int SH = NDIV - j;
        logic [CMP_W-1:0] dvs;
        logic             gex, gey;
        logic [Q_W-1:0]   n_qx, n_qy;

        assign dvs = CMP_W'(r_dad[j-1]) << SH;
        assign gex = r_rx[j-1] >= dvs;
        assign gey = r_ry[j-1] >= dvs;

        always_comb begin
            n_qx     = r_qx[j-1];
            n_qy     = r_qy[j-1];
            n_qx[SH] = gex;
            n_qy[SH] = gey;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[j] <= 1'b0;
            else          r_dv[j] <= r_dv[j-1];
            r_dmeta[j] <= r_dmeta[j-1];
            r_dflg[j]  <= r_dflg[j-1];
            r_qx[j]    <= n_qx;
            r_qy[j]    <= n_qy;
        end

        if (j < NDIV) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rx[j]  <= gex ? r_rx[j-1] - dvs : r_rx[j-1];
                r_ry[j]  <= gey ? r_ry[j-1] - dvs : r_ry[j-1];
                r_dad[j] <= r_dad[j-1];
            end
        end
    end

    // Output stage: apply sign, saturation and the zero-divisor case
    t_flags                  of;
    logic signed [OUT_W-1:0] n_mx, n_my;
    assign of = r_dflg[NDIV];

    always_comb begin
        if (of.dz)         n_mx = '0;
        else if (of.satpx) n_mx = SAT_MAX;
        else if (of.satnx) n_mx = SAT_MIN;
        else if (of.negx)  n_mx = -signed'(r_qx[NDIV]);
        else               n_mx = signed'(r_qx[NDIV]);
        if (of.dz)         n_my = '0;
        else if (of.satpy) n_my = SAT_MAX;
        else if (of.satny) n_my = SAT_MIN;
        else if (of.negy)  n_my = -signed'(r_qy[NDIV]);
        else               n_my = signed'(r_qy[NDIV]);
    end

    logic                    r_done;
    logic signed [OUT_W-1:0] r_mx, r_my;
    logic                    r_inside, r_fwd;
    t_meta                   r_ometa;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r_dv[NDIV];
        r_mx     <= n_mx;
        r_my     <= n_my;
        r_inside <= of.in_canvas;
        r_fwd    <= of.fwd;
        r_ometa  <= r_dmeta[NDIV];
    end

    assign o_done          = r_done;
    assign o_mapped_x      = r_mx;
    assign o_mapped_y      = r_my;
    assign o_inside_canvas = r_inside;
    assign o_forward_event = r_fwd;
    assign o_out_polarity  = r_ometa.pol;
    assign o_out_channel   = r_ometa.chan;
    assign o_out_stamp     = r_ometa.stamp;

endmodule

/* sv/evhr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evhr_checker
// Port-level checks on the event homography remap, bound to the top level.
// ----------------------------------------------------------------------------
module evhr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 o_cfg_ready,
    input logic                                 o_done,
    input logic signed [evhr_pkg::OUT_W-1:0]    o_mapped_x,
    input logic signed [evhr_pkg::OUT_W-1:0]    o_mapped_y,
    input logic                                 o_inside_canvas,
    input logic                                 o_forward_event
);
    // Each accepted transaction is followed by its result strobe on o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##23 o_done)
        else $error("result strobe missing after accepted transaction");

    // Block never refuses an event or a configuration write
    a_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("block stalled a channel");

    // A point inside the canvas has non-negative coordinates
    a_inside_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_inside_canvas |-> !o_mapped_x[15] && !o_mapped_y[15])
        else $error("inside flag with negative coordinate");

    // A forwarded event has a row no larger than 255
    a_fwd_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_forward_event |-> o_mapped_y <= 16'sd255)
        else $error("forwarded event with row above 255");

endmodule

bind event_homography_remap evhr_checker u_evhr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_cfg_ready     (o_cfg_ready),
    .o_done          (o_done),
    .o_mapped_x      (o_mapped_x),
    .o_mapped_y      (o_mapped_y),
    .o_inside_canvas (o_inside_canvas),
    .o_forward_event (o_forward_event)
);
